/* design/reloading_interval_timer_unit_defines.svh */
// Assertion macros for the reloading interval timer checker.
// Used by rit_port_checker only; expects clk and rst_n in scope.
`ifndef RELOADING_INTERVAL_TIMER_UNIT_DEFINES_SVH
`define RELOADING_INTERVAL_TIMER_UNIT_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define RIT_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define RIT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/rit_pkg.sv */
// Shared types, constants and mixed-radix helpers for the interval timer.
// No dependencies; imported by rit_div, reloading_interval_timer_unit and rit_port_checker.
`default_nettype none

package rit_pkg;

    localparam int TICK_WIDTH_DEF = 32;
    localparam int HOUR_WIDTH_DEF = 16;

    localparam int DIV_W      = 20;   // ticks_per_ms and leftover
    localparam int TGT_HOUR_W = 16;
    localparam int B60_W      = 6;    // minutes and seconds
    localparam int MS_W       = 10;
    localparam int RELOAD_W   = 17;
    localparam int KIND_W     = 2;
    localparam int FLAGS_W    = 2;
    localparam int LOW_TIME_W = 2 * B60_W + MS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIV_W;

    localparam logic [MS_W:0]  MS_PER_SEC = (MS_W + 1)'(1000);
    localparam logic [B60_W:0] BASE_60    = (B60_W + 1)'(60);

    // all ones: unlimited reloads
    localparam logic signed [RELOAD_W-1:0] RELOAD_UNLIMITED = '1;
    localparam logic signed [RELOAD_W-1:0] RELOAD_ONE = RELOAD_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_CLEAR
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_MS,
        REG_TARGET_HOURS,
        REG_TARGET_MINUTES,
        REG_TARGET_SECONDS,
        REG_TARGET_MILLIS,
        REG_RELOAD_COUNT,
        REG_PERIODIC_MODE
    } cfg_reg_t;

    typedef struct packed {
        logic done;
        logic hour_over;
    } div_stat_t;

    // {carry, sum mod 1000}; sum must stay below 2000
    function automatic logic [MS_W:0] wrap_ms(input logic [MS_W:0] sum);
        if (sum >= MS_PER_SEC)
        begin
            wrap_ms = {1'b1, MS_W'(sum - MS_PER_SEC)};
        end
        else
        begin
            wrap_ms = {1'b0, sum[MS_W-1:0]};
        end
    endfunction

    // {carry, sum mod 60}; sum must stay below 120
    function automatic logic [B60_W:0] wrap_60(input logic [B60_W:0] sum);
        if (sum >= BASE_60)
        begin
            wrap_60 = {1'b1, B60_W'(sum - BASE_60)};
        end
        else
        begin
            wrap_60 = {1'b0, sum[B60_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

/* design/rit_div.sv */
// Bit-serial restoring divider whose quotient bits are shifted straight
// into an hours:minutes:seconds:millis accumulator. Depends on rit_pkg.
`default_nettype none

module rit_div
    import rit_pkg::*;
#(
    parameter int NUM_WIDTH  = TICK_WIDTH_DEF + 1,
    parameter int HOUR_WIDTH = HOUR_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [NUM_WIDTH-1:0]  dividend,
    input  wire logic [DIV_W-1:0]      divisor,
    output div_stat_t                  stat,
    output logic [HOUR_WIDTH-1:0]      q_hours,
    output logic [B60_W-1:0]           q_minutes,
    output logic [B60_W-1:0]           q_seconds,
    output logic [MS_W-1:0]            q_millis,
    output logic [DIV_W-1:0]           remainder
);

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [NUM_WIDTH-1:0]  num_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic                  over_reg;
    logic [HOUR_WIDTH-1:0] qh_reg;
    logic [B60_W-1:0]      qm_reg;
    logic [B60_W-1:0]      qs_reg;
    logic [MS_W-1:0]       qms_reg;

    logic [DIV_W:0]        trial;
    logic                  fits;
    logic [DIV_W-1:0]      rem_next;
    logic [MS_W:0]         ms_step;
    logic [B60_W:0]        s_step;
    logic [B60_W:0]        m_step;
    logic [HOUR_WIDTH:0]   h_step;

    always_comb
    begin
        trial    = {rem_reg, num_reg[NUM_WIDTH-1]};
        fits     = (trial >= {1'b0, divisor});
        rem_next = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
        // accumulator = 2 * accumulator + quotient bit, carried per field
        ms_step  = wrap_ms({qms_reg, fits});
        s_step   = wrap_60({qs_reg, ms_step[MS_W]});
        m_step   = wrap_60({qm_reg, s_step[B60_W]});
        h_step   = {qh_reg, m_step[B60_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend;
            rem_reg  <= '0;
            over_reg <= 1'b0;
            qh_reg   <= '0;
            qm_reg   <= '0;
            qs_reg   <= '0;
            qms_reg  <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= rem_next;
            // sticky: quotient hours no longer fit
            over_reg <= over_reg | h_step[HOUR_WIDTH];
            qh_reg   <= h_step[HOUR_WIDTH-1:0];
            qm_reg   <= m_step[B60_W-1:0];
            qs_reg   <= s_step[B60_W-1:0];
            qms_reg  <= ms_step[MS_W-1:0];
        end
    end

    assign stat.done      = done_reg;
    assign stat.hour_over = over_reg;
    assign q_hours        = qh_reg;
    assign q_minutes      = qm_reg;
    assign q_seconds      = qs_reg;
    assign q_millis       = qms_reg;
    assign remainder      = rem_reg;

endmodule

`default_nettype wire

/* design/reloading_interval_timer_unit.sv */
// Reloading interval timer: one request per command (tick, start, stop,
// clear), one result per request. A tick taken while running with a nonzero
// ticks_per_ms runs the elapsed ticks plus the leftover through a bit-serial
// divider, one quotient bit per cycle, then compares the count with the
// target; a tick taken while running with a zero ticks_per_ms skips the
// divider, and every other request goes straight to the output stage. No
// request is taken while one is in flight, but the result sits in an output
// register, so a new request is accepted while the previous result still
// waits. Hours saturate at 2^HOUR_WIDTH - 1. Writing a target register
// clears the elapsed count; writing reload_count also loads the reloads
// remaining. Depends on rit_pkg and rit_div.
`default_nettype none

module reloading_interval_timer_unit
    import rit_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF,
    parameter int HOUR_WIDTH = HOUR_WIDTH_DEF
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // sys_ticks
    input  wire logic [((TICK_WIDTH+7)/8)*8-1:0]          s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]                        s_tuser,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // elapsed_hours, elapsed_minutes, elapsed_seconds, elapsed_millis
    output logic [((HOUR_WIDTH+LOW_TIME_W+7)/8)*8-1:0]    m_tdata,
    // expired, running
    output logic [FLAGS_W-1:0]                            m_tuser,
    input  wire logic                                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                    cfg_data
);

    localparam int NUM_W    = ((TICK_WIDTH > DIV_W) ? TICK_WIDTH : DIV_W) + 1;
    localparam int M_DATA_W = ((HOUR_WIDTH + LOW_TIME_W + 7) / 8) * 8;
    localparam int CMP_HW   = (HOUR_WIDTH > TGT_HOUR_W + 1) ? HOUR_WIDTH : TGT_HOUR_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t                       state_reg;

    logic [DIV_W-1:0]             ticks_per_ms_reg;
    logic [TGT_HOUR_W-1:0]        target_hours_reg;
    logic [B60_W-1:0]             target_minutes_reg;
    logic [B60_W-1:0]             target_seconds_reg;
    logic [MS_W-1:0]              target_millis_reg;
    logic signed [RELOAD_W-1:0]   reload_count_reg;
    logic                         periodic_mode_reg;

    logic                         run_reg;
    logic [TICK_WIDTH-1:0]        last_tick_reg;
    logic [DIV_W-1:0]             leftover_reg;
    logic [HOUR_WIDTH-1:0]        count_hours_reg;
    logic [B60_W-1:0]             count_minutes_reg;
    logic [B60_W-1:0]             count_seconds_reg;
    logic [MS_W-1:0]              count_millis_reg;
    logic signed [RELOAD_W-1:0]   reloads_left_reg;

    logic [TICK_WIDTH-1:0]        delta_reg;
    logic [TGT_HOUR_W:0]          tgt_hours_reg;
    logic [B60_W-1:0]             tgt_minutes_reg;
    logic [B60_W-1:0]             tgt_seconds_reg;
    logic [MS_W-1:0]              tgt_millis_reg;
    logic                         hit_reg;

    logic                         m_tvalid_reg;
    logic [M_DATA_W-1:0]          m_tdata_reg;
    logic [FLAGS_W-1:0]           m_tuser_reg;

    logic [TICK_WIDTH-1:0]        now;
    kind_t                        kind;
    logic                         accept;

    logic                         div_start;
    logic [NUM_W-1:0]             div_dividend;
    div_stat_t                    div_stat;
    logic [HOUR_WIDTH-1:0]        div_q_hours;
    logic [B60_W-1:0]             div_q_minutes;
    logic [B60_W-1:0]             div_q_seconds;
    logic [MS_W-1:0]              div_q_millis;
    logic [DIV_W-1:0]             div_rem;

    logic [MS_W:0]                t_ms;
    logic [B60_W:0]               t_s;
    logic [B60_W:0]               t_m;
    logic [TGT_HOUR_W:0]          t_h;

    logic [MS_W:0]                a_ms;
    logic [B60_W:0]               a_s;
    logic [B60_W:0]               a_m;
    logic [HOUR_WIDTH:0]          a_h;
    logic                         a_sat;

    logic [CMP_HW-1:0]            cmp_count_h;
    logic [CMP_HW-1:0]            cmp_tgt_h;
    logic                         count_ge_target;
    logic                         reloads_pos;
    logic                         reloads_unlim;

    assign now      = s_tdata[TICK_WIDTH-1:0];
    assign kind     = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign div_start    = (state_reg == ST_SUM) && (ticks_per_ms_reg != '0);
    assign div_dividend = NUM_W'(delta_reg) + NUM_W'(leftover_reg);

    rit_div #(
        .NUM_WIDTH  (NUM_W),
        .HOUR_WIDTH (HOUR_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (ticks_per_ms_reg),
        .stat      (div_stat),
        .q_hours   (div_q_hours),
        .q_minutes (div_q_minutes),
        .q_seconds (div_q_seconds),
        .q_millis  (div_q_millis),
        .remainder (div_rem)
    );

    // Target folded into proper ranges so a field-by-field compare
    // matches the weighted-sum compare.
    always_comb
    begin
        t_ms = wrap_ms({1'b0, target_millis_reg});
        t_s  = wrap_60({1'b0, target_seconds_reg} + (B60_W + 1)'(t_ms[MS_W]));
        t_m  = wrap_60({1'b0, target_minutes_reg} + (B60_W + 1)'(t_s[B60_W]));
        t_h  = {1'b0, target_hours_reg} + (TGT_HOUR_W + 1)'(t_m[B60_W]);
    end

    // count + quotient, carried field by field
    always_comb
    begin
        a_ms  = wrap_ms({1'b0, count_millis_reg} + {1'b0, div_q_millis});
        a_s   = wrap_60({1'b0, count_seconds_reg} + {1'b0, div_q_seconds}
                        + (B60_W + 1)'(a_ms[MS_W]));
        a_m   = wrap_60({1'b0, count_minutes_reg} + {1'b0, div_q_minutes}
                        + (B60_W + 1)'(a_s[B60_W]));
        a_h   = {1'b0, count_hours_reg} + {1'b0, div_q_hours}
                + (HOUR_WIDTH + 1)'(a_m[B60_W]);
        a_sat = div_stat.hour_over | a_h[HOUR_WIDTH];
    end

    always_comb
    begin
        cmp_count_h     = CMP_HW'(count_hours_reg);
        cmp_tgt_h       = CMP_HW'(tgt_hours_reg);
        count_ge_target = (cmp_count_h > cmp_tgt_h)
            || ((cmp_count_h == cmp_tgt_h)
                && ((count_minutes_reg > tgt_minutes_reg)
                    || ((count_minutes_reg == tgt_minutes_reg)
                        && ((count_seconds_reg > tgt_seconds_reg)
                            || ((count_seconds_reg == tgt_seconds_reg)
                                && (count_millis_reg >= tgt_millis_reg))))));
        reloads_pos   = !reloads_left_reg[RELOAD_W-1] && (reloads_left_reg != '0);
        reloads_unlim = (reloads_left_reg == RELOAD_UNLIMITED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            ticks_per_ms_reg   <= '0;
            target_hours_reg   <= '0;
            target_minutes_reg <= '0;
            target_seconds_reg <= '0;
            target_millis_reg  <= '0;
            reload_count_reg   <= '0;
            periodic_mode_reg  <= 1'b0;
            run_reg            <= 1'b0;
            last_tick_reg      <= '0;
            leftover_reg       <= '0;
            count_hours_reg    <= '0;
            count_minutes_reg  <= '0;
            count_seconds_reg  <= '0;
            count_millis_reg   <= '0;
            reloads_left_reg   <= '0;
            delta_reg          <= '0;
            tgt_hours_reg      <= '0;
            tgt_minutes_reg    <= '0;
            tgt_seconds_reg    <= '0;
            tgt_millis_reg     <= '0;
            hit_reg            <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            m_tdata_reg        <= '0;
            m_tuser_reg        <= '0;
        end
        else
        begin
            if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                        case (kind)
                            KIND_TICK:
                            begin
                                last_tick_reg <= now;
                                if (run_reg)
                                begin
                                    delta_reg       <= now - last_tick_reg;
                                    tgt_hours_reg   <= t_h;
                                    tgt_minutes_reg <= t_m[B60_W-1:0];
                                    tgt_seconds_reg <= t_s[B60_W-1:0];
                                    tgt_millis_reg  <= t_ms[MS_W-1:0];
                                    state_reg       <= ST_SUM;
                                end
                            end
                            KIND_START:
                            begin
                                last_tick_reg <= now;
                                run_reg       <= 1'b1;
                            end
                            KIND_STOP:
                            begin
                                run_reg <= 1'b0;
                            end
                            KIND_CLEAR:
                            begin
                                count_hours_reg   <= '0;
                                count_minutes_reg <= '0;
                                count_seconds_reg <= '0;
                                count_millis_reg  <= '0;
                                reloads_left_reg  <= reload_count_reg;
                            end
                            default:
                            begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end

                ST_SUM:
                begin
                    // zero divisor: time frozen, leftover kept
                    state_reg <= (ticks_per_ms_reg != '0) ? ST_DIV : ST_CMP;
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        leftover_reg <= div_rem;
                        if (a_sat)
                        begin
                            count_hours_reg   <= '1;
                            count_minutes_reg <= '0;
                            count_seconds_reg <= '0;
                            count_millis_reg  <= '0;
                        end
                        else
                        begin
                            count_hours_reg   <= a_h[HOUR_WIDTH-1:0];
                            count_minutes_reg <= a_m[B60_W-1:0];
                            count_seconds_reg <= a_s[B60_W-1:0];
                            count_millis_reg  <= a_ms[MS_W-1:0];
                        end
                        state_reg <= ST_CMP;
                    end
                end

                ST_CMP:
                begin
                    if (count_ge_target)
                    begin
                        hit_reg <= 1'b1;
                        if (!periodic_mode_reg)
                        begin
                            run_reg <= 1'b0;
                        end
                        else
                        begin
                            leftover_reg <= '0;
                            if (reloads_pos || reloads_unlim)
                            begin
                                count_hours_reg   <= '0;
                                count_minutes_reg <= '0;
                                count_seconds_reg <= '0;
                                count_millis_reg  <= '0;
                                if (reloads_pos)
                                begin
                                    reloads_left_reg <= reloads_left_reg - RELOAD_ONE;
                                end
                                run_reg <= 1'b1;
                            end
                            else
                            begin
                                run_reg <= 1'b0;
                            end
                        end
                    end
                    state_reg <= ST_OUT;
                end

                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_DATA_W'({count_millis_reg, count_seconds_reg,
                                                   count_minutes_reg, count_hours_reg});
                        m_tuser_reg  <= {run_reg, hit_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // register writes must arrive only while no request is in flight; the block itself does not enforce this
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TICKS_PER_MS:
                    begin
                        ticks_per_ms_reg <= cfg_data[DIV_W-1:0];
                    end
                    REG_TARGET_HOURS:
                    begin
                        target_hours_reg  <= cfg_data[TGT_HOUR_W-1:0];
                        count_hours_reg   <= '0;
                        count_minutes_reg <= '0;
                        count_seconds_reg <= '0;
                        count_millis_reg  <= '0;
                    end
                    REG_TARGET_MINUTES:
                    begin
                        target_minutes_reg <= cfg_data[B60_W-1:0];
                        count_hours_reg    <= '0;
                        count_minutes_reg  <= '0;
                        count_seconds_reg  <= '0;
                        count_millis_reg   <= '0;
                    end
                    REG_TARGET_SECONDS:
                    begin
                        target_seconds_reg <= cfg_data[B60_W-1:0];
                        count_hours_reg    <= '0;
                        count_minutes_reg  <= '0;
                        count_seconds_reg  <= '0;
                        count_millis_reg   <= '0;
                    end
                    REG_TARGET_MILLIS:
                    begin
                        target_millis_reg <= cfg_data[MS_W-1:0];
                        count_hours_reg   <= '0;
                        count_minutes_reg <= '0;
                        count_seconds_reg <= '0;
                        count_millis_reg  <= '0;
                    end
                    REG_RELOAD_COUNT:
                    begin
                        reload_count_reg <= signed'(cfg_data[RELOAD_W-1:0]);
                        reloads_left_reg <= signed'(cfg_data[RELOAD_W-1:0]);
                    end
                    REG_PERIODIC_MODE:
                    begin
                        periodic_mode_reg <= cfg_data[0];
                    end
                    default:
                    begin
                        periodic_mode_reg <= periodic_mode_reg;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* design/rit_port_checker.sv */
// Port-level checks for reloading_interval_timer_unit, bound to the top.
// Depends on rit_pkg and reloading_interval_timer_unit_defines.svh.
`default_nettype none
`include "reloading_interval_timer_unit_defines.svh"

module rit_port_checker
    import rit_pkg::*;
#(
    parameter int HOUR_WIDTH = HOUR_WIDTH_DEF
)
(
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   s_tvalid,
    input wire logic                                   s_tready,
    input wire logic                                   m_tvalid,
    input wire logic                                   m_tready,
    input wire logic [((HOUR_WIDTH+LOW_TIME_W+7)/8)*8-1:0] m_tdata,
    input wire logic [FLAGS_W-1:0]                     m_tuser
);

    localparam int MIN_LO = HOUR_WIDTH;
    localparam int MIN_HI = MIN_LO + B60_W - 1;
    localparam int SEC_LO = MIN_HI + 1;
    localparam int SEC_HI = SEC_LO + B60_W - 1;
    localparam int MS_LO  = SEC_HI + 1;
    localparam int MS_HI  = MS_LO + MS_W - 1;

    `RIT_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !m_tvalid, "result valid during reset")

    `RIT_ASSERT_CLK(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `RIT_ASSERT_CLK(a_one_request_at_a_time, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    `RIT_ASSERT_CLK(a_fields_in_range, m_tvalid |-> (m_tdata[MIN_HI:MIN_LO] < 60) && (m_tdata[SEC_HI:SEC_LO] < 60) && (m_tdata[MS_HI:MS_LO] < 1000), "elapsed field out of range")

    `RIT_ASSERT_CLK(a_reload_clears, m_tvalid && m_tuser[0] && m_tuser[1] |-> (m_tdata[MS_HI:0] == '0), "reload left a nonzero count")

endmodule

bind reloading_interval_timer_unit rit_port_checker #(
    .HOUR_WIDTH (HOUR_WIDTH)
) u_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
